>>> sv/msp_pkg.sv
// Shared types and constants of the multi-axis step pulse generator.
package msp_pkg;

    localparam int NUM_MOTORS = 4;
    localparam int MIDX_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int IDLE_W     = $clog2(NUM_MOTORS + 1);
    localparam int STEPS_W    = 24;
    localparam int CD_W       = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_MOVE   = 2'd1;
    localparam logic [1:0] CMD_ENABLE = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [1:0] REG_MERGE = 2'd0;
    localparam logic [1:0] REG_HOLD  = 2'd1;

    localparam logic [31:0] MISSED_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [STEPS_W-1:0] steps;
        logic [STEPS_W-1:0] half;
        logic [CD_W-1:0]    cd;
    } msp_entry_t;

    typedef struct packed {
        logic [CD_W-1:0]    cd1;
        logic               toggle;
        logic               new_level;
        logic [STEPS_W-1:0] steps_new;
        logic [CD_W-1:0]    reload;
    } msp_calc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EX1,
        ST_EX2,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FIN,
        ST_DONE
    } msp_state_t;

endpackage

>>> sv/multi_axis_step_pulse_generator_core.sv
// Top level: command sequencer around the per-motor state memory.
// Paths from input accept to result: a tick without a service pass, an enable or an unused
// command goes straight to the result state; a move runs a min scan (read, then compare per
// busy motor); a tick with a service pass reads, updates and writes each busy motor.
// One item at a time, the next taken in the cycle after the result loads; it is taken while
// that result waits at the output. Reset (rst_n low, async) idles all motors, drivers off.
module multi_axis_step_pulse_generator_core
    import msp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // motor[1:0], direction[2], step_count[26:3], full_period[50:27], enable[51]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // step_pins[3:0], dir_pins[7:4], enable_n_pins[11:8], idle_motors[15:12],
    // all_idle_event[16], timer_running[17], missed_steps[49:18]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    msp_state_t state_reg, state_next;

    logic [NUM_MOTORS-1:0] busy_reg, step_reg, dir_reg, en_n_reg;
    logic [31:0]           timer_count_reg, match_reg, missed_reg;
    logic                  timer_on_reg, event_reg, have_next_reg, pass_reg;
    logic [IDLE_W-1:0]     last_idle_reg;
    logic [15:0]           merge_reg, hold_reg;
    logic [CD_W-1:0]       next_reg;
    logic [MIDX_W-1:0]     idx_reg;
    msp_entry_t            e1_entry_reg;
    msp_calc_t             e1_calc_reg;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;

    logic [MIDX_W-1:0] motor;
    logic              motor_ok;
    logic              accept;
    logic              last_idx;
    logic [31:0]       tick_count;
    logic [CD_W-1:0]   move_cd;
    logic              mem_we;
    logic [MIDX_W-1:0] mem_waddr, mem_raddr;
    msp_entry_t        mem_wdata, mem_rdata;
    msp_calc_t         calc;
    logic [CD_W-1:0]   cd2;
    logic              miss;
    logic [IDLE_W-1:0] idle_cnt;
    logic              load_out;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign motor     = s_tdata[MIDX_W-1:0];
    assign motor_ok  = ({30'd0, s_tdata[1:0]} < NUM_MOTORS);
    assign last_idx  = (idx_reg == MIDX_W'(NUM_MOTORS - 1));
    assign tick_count = timer_count_reg + 32'd1;
    assign move_cd   = timer_count_reg + {16'd0, hold_reg};
    assign load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    msp_state_ram u_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    msp_toggle_calc u_calc
    (
        .entry        (mem_rdata),
        .match_value  (match_reg),
        .merge_window (merge_reg),
        .level        (step_reg[idx_reg]),
        .calc         (calc)
    );

    always_comb
    begin
        cd2  = e1_calc_reg.cd1 + e1_calc_reg.reload;
        miss = e1_calc_reg.toggle && ($signed(cd2) <= 0);
        if (miss)
        begin
            cd2 = e1_calc_reg.reload;
        end
        else if (!e1_calc_reg.toggle)
        begin
            cd2 = e1_calc_reg.cd1;
        end
    end

    always_comb
    begin
        idle_cnt = '0;
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            idle_cnt = idle_cnt + IDLE_W'(~busy_reg[k]);
        end
    end

    always_comb
    begin
        mem_raddr = idx_reg;
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '{steps: e1_calc_reg.steps_new, half: e1_entry_reg.half, cd: cd2};
        if (state_reg == ST_IDLE)
        begin
            mem_we    = accept && (s_tuser == CMD_MOVE) && motor_ok;
            mem_waddr = motor;
            mem_wdata = '{steps: s_tdata[26:3], half: s_tdata[50:27], cd: move_cd};
        end
        else if (state_reg == ST_EX2)
        begin
            mem_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_TICK && timer_on_reg && tick_count == match_reg)
                        state_next = ST_RD;
                    else if (s_tuser == CMD_MOVE && motor_ok)
                        state_next = ST_SCAN_RD;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_RD:
            begin
                if (busy_reg[idx_reg])
                    state_next = ST_EX1;
                else if (last_idx)
                    state_next = ST_FIN;
            end
            ST_EX1:      state_next = ST_EX2;
            ST_EX2:      state_next = last_idx ? ST_FIN : ST_RD;
            ST_SCAN_RD:
            begin
                if (busy_reg[idx_reg])
                    state_next = ST_SCAN_CMP;
                else if (last_idx)
                    state_next = ST_FIN;
            end
            ST_SCAN_CMP: state_next = last_idx ? ST_FIN : ST_SCAN_RD;
            ST_FIN:      state_next = ST_DONE;
            ST_DONE:     state_next = load_out ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= '0;
            step_reg        <= '0;
            dir_reg         <= '0;
            en_n_reg        <= '1;
            timer_count_reg <= '0;
            match_reg       <= '0;
            missed_reg      <= '0;
            timer_on_reg    <= 1'b0;
            event_reg       <= 1'b0;
            have_next_reg   <= 1'b0;
            pass_reg        <= 1'b0;
            last_idle_reg   <= IDLE_W'(NUM_MOTORS);
            merge_reg       <= '0;
            hold_reg        <= 16'd1;
            next_reg        <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_MERGE)
                merge_reg <= cfg_data;
            if (cfg_valid && cfg_index == REG_HOLD)
                hold_reg <= cfg_data;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        event_reg     <= 1'b0;
                        idx_reg       <= '0;
                        have_next_reg <= 1'b0;
                        case (s_tuser)
                            CMD_TICK:
                            begin
                                if (timer_on_reg)
                                    timer_count_reg <= tick_count;
                                pass_reg <= 1'b1;
                            end
                            CMD_MOVE:
                            begin
                                if (motor_ok)
                                begin
                                    en_n_reg[motor] <= 1'b0;
                                    step_reg[motor] <= 1'b0;
                                    dir_reg[motor]  <= s_tdata[2];
                                    busy_reg[motor] <= (s_tdata[26:3] != '0);
                                    next_reg        <= move_cd;
                                end
                                pass_reg <= 1'b0;
                            end
                            CMD_ENABLE:
                            begin
                                if (motor_ok)
                                begin
                                    busy_reg[motor] <= 1'b0;
                                    en_n_reg[motor] <= ~s_tdata[51];
                                    step_reg[motor] <= 1'b0;
                                end
                            end
                            default:
                            begin
                                pass_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_RD, ST_SCAN_RD:
                begin
                    if (!busy_reg[idx_reg] && !last_idx)
                        idx_reg <= idx_reg + MIDX_W'(1);
                end
                ST_EX2:
                begin
                    step_reg[idx_reg] <= e1_calc_reg.new_level;
                    busy_reg[idx_reg] <= (e1_calc_reg.steps_new != '0);
                    if (miss && missed_reg != MISSED_MAX)
                        missed_reg <= missed_reg + 32'd1;
                    if (e1_calc_reg.steps_new != '0)
                    begin
                        if (!have_next_reg || $signed(cd2) < $signed(next_reg))
                            next_reg <= cd2;
                        have_next_reg <= 1'b1;
                    end
                    if (!last_idx)
                        idx_reg <= idx_reg + MIDX_W'(1);
                end
                ST_SCAN_CMP:
                begin
                    if ($signed(mem_rdata.cd) < $signed(next_reg))
                        next_reg <= mem_rdata.cd;
                    if (!last_idx)
                        idx_reg <= idx_reg + MIDX_W'(1);
                end
                ST_FIN:
                begin
                    if (!pass_reg)
                    begin
                        match_reg    <= next_reg;
                        timer_on_reg <= 1'b1;
                    end
                    else if (have_next_reg)
                    begin
                        match_reg       <= next_reg;
                        timer_count_reg <= 32'hFFFF_FFFF;
                        last_idle_reg   <= idle_cnt;
                    end
                    else
                    begin
                        timer_on_reg    <= 1'b0;
                        timer_count_reg <= '0;
                        event_reg       <= (idle_cnt != last_idle_reg);
                        last_idle_reg   <= idle_cnt;
                    end
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    // Hold the first update stage of the motor being serviced
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EX1)
        begin
            e1_entry_reg <= mem_rdata;
            e1_calc_reg  <= calc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= {6'd0, missed_reg, timer_on_reg, event_reg, ~busy_reg,
                           en_n_reg, dir_reg, step_reg};
        end
    end

endmodule

>>> sv/msp_state_ram.sv
// Per-motor state memory: one write port, one registered read port.
module msp_state_ram
    import msp_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [MIDX_W-1:0] waddr,
    input  msp_entry_t        wdata,
    input  logic [MIDX_W-1:0] raddr,
    output msp_entry_t        rdata
);

    msp_entry_t mem [NUM_MOTORS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/msp_toggle_calc.sv
// First half of a motor update: elapsed interval, toggle decision, reload value.
module msp_toggle_calc
    import msp_pkg::*;
(
    input  msp_entry_t  entry,
    input  logic [31:0] match_value,
    input  logic [15:0] merge_window,
    input  logic        level,
    output msp_calc_t   calc
);

    logic [CD_W-1:0] cd1;
    logic            tog;
    logic            lvl;

    always_comb
    begin
        cd1 = entry.cd - match_value;
        tog = $signed({cd1[CD_W-1], cd1}) <= $signed({17'd0, merge_window});
        lvl = level ^ tog;
        calc.cd1       = cd1;
        calc.toggle    = tog;
        calc.new_level = lvl;
        // drop one step on each falling edge
        calc.steps_new = entry.steps - {{(STEPS_W-1){1'b0}}, tog & ~lvl};
        calc.reload    = {{(CD_W-STEPS_W+1){1'b0}}, entry.half[STEPS_W-1:1]} - 32'd1;
    end

endmodule

>>> sv/msp_checker.sv
// Port-level checker for the step pulse generator, bound to the top level.
module msp_port_props
    import msp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> m_tdata[15:12] == 4'hF && !m_tdata[17])
        else $error("all-idle event with busy motor or running timer");

    a_busy_runs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15:12] != 4'hF |-> m_tdata[17])
        else $error("busy motor with timer stopped");

endmodule

bind multi_axis_step_pulse_generator_core msp_port_props u_msp_port_props
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/msp_checker.sv
// Checker: predicts step pulse generator results from accepted items and compares them.
module msp_checker
    import msp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    results_seen,
    output int                    passes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [23:0] steps_left [NUM_MOTORS];
    logic [23:0] half_src   [NUM_MOTORS];
    logic [31:0] countdown  [NUM_MOTORS];
    logic [3:0]  step_lvl, dir_lvl, en_n_lvl;
    logic [31:0] tmr_count, tmr_match, missed;
    logic        tmr_on;
    int          last_idle;
    logic [15:0] merge_win, hold_dly;

    logic [49:0] status_q [$];

    function automatic logic [31:0] reload_of(int m);
        return ({8'd0, half_src[m]} >> 1) - 32'd1;
    endfunction

    task automatic run_service(output logic ev);
        logic [31:0] delta;
        int          idle;
        bit          have_next;
        int          next_cd;
        logic [3:0]  bit_m;
        delta = tmr_match;
        idle = NUM_MOTORS;
        have_next = 0;
        next_cd = 0;
        ev = 0;
        for (int m = 0; m < NUM_MOTORS; m++)
        begin
            bit_m = 4'(1 << m);
            if (steps_left[m] == 0)
                continue;
            idle--;
            countdown[m] = countdown[m] - delta;
            if ($signed(countdown[m]) <= int'(merge_win))
            begin
                step_lvl ^= bit_m;
                if ((step_lvl & bit_m) == 0)
                begin
                    steps_left[m] = steps_left[m] - 24'd1;
                    if (steps_left[m] == 0)
                        idle++;
                end
                countdown[m] = countdown[m] + reload_of(m);
                if ($signed(countdown[m]) <= 0)
                begin
                    if (missed != MISSED_MAX)
                        missed++;
                    countdown[m] = reload_of(m);
                end
            end
            if (steps_left[m] != 0)
            begin
                if (!have_next || $signed(countdown[m]) < next_cd)
                    next_cd = $signed(countdown[m]);
                have_next = 1;
            end
        end
        if (!have_next)
        begin
            tmr_on = 0;
            tmr_count = '0;
            if (idle != last_idle)
                ev = 1;
        end
        else
        begin
            tmr_match = next_cd;
            tmr_count = 32'hFFFF_FFFF;
        end
        last_idle = idle;
    endtask

    // Advance the model by one item and return the expected status word.
    task automatic predict_status(input logic [1:0] cmd, input logic [IN_DATA_W-1:0] d,
                                  output logic [49:0] status);
        int          m;
        logic [3:0]  bit_m, idle_bits;
        logic        ev;
        int          next_cd;
        ev = 0;
        m = int'(d[1:0]);
        bit_m = 4'(1 << m);
        if (cmd == CMD_TICK)
        begin
            if (tmr_on)
            begin
                tmr_count++;
                if (tmr_count == tmr_match)
                begin
                    run_service(ev);
                    passes_seen++;
                end
            end
        end
        else if (cmd == CMD_MOVE)
        begin
            en_n_lvl &= ~bit_m;
            step_lvl &= ~bit_m;
            dir_lvl = d[2] ? (dir_lvl | bit_m) : (dir_lvl & ~bit_m);
            half_src[m] = d[50:27];
            steps_left[m] = d[26:3];
            countdown[m] = tmr_count + {16'd0, hold_dly};
            next_cd = $signed(countdown[m]);
            for (int k = 0; k < NUM_MOTORS; k++)
                if (steps_left[k] != 0 && $signed(countdown[k]) < next_cd)
                    next_cd = $signed(countdown[k]);
            tmr_match = next_cd;
            tmr_on = 1;
        end
        else if (cmd == CMD_ENABLE)
        begin
            steps_left[m] = '0;
            if (d[51])
                en_n_lvl &= ~bit_m;
            else
                en_n_lvl |= bit_m;
            step_lvl &= ~bit_m;
        end
        for (int k = 0; k < NUM_MOTORS; k++)
            idle_bits[k] = (steps_left[k] == 0);
        status = {missed, tmr_on, ev, idle_bits, en_n_lvl, dir_lvl, step_lvl};
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [49:0] want;
        logic [49:0] got;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_MOTORS; k++)
            begin
                steps_left[k] = '0;
                half_src[k] = '0;
                countdown[k] = '0;
            end
            step_lvl = '0;
            dir_lvl = '0;
            en_n_lvl = '1;
            tmr_count = '0;
            tmr_match = '0;
            tmr_on = 0;
            missed = '0;
            last_idle = NUM_MOTORS;
            merge_win = '0;
            hold_dly = 16'd1;
            status_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MERGE)
                    merge_win = cfg_data;
                else if (cfg_index == REG_HOLD)
                    hold_dly = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                predict_status(s_tuser, s_tdata, want);
                status_q.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[49:0];
                if (status_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, got %0h", $time, got);
                end
                else
                begin
                    want = status_q.pop_front();
                    results_seen++;
                    check_field("step_pins", 32'(want[3:0]), 32'(got[3:0]));
                    check_field("dir_pins", 32'(want[7:4]), 32'(got[7:4]));
                    check_field("enable_n_pins", 32'(want[11:8]), 32'(got[11:8]));
                    check_field("idle_motors", 32'(want[15:12]), 32'(got[15:12]));
                    check_field("all_idle_event", 32'(want[16]), 32'(got[16]));
                    check_field("timer_running", 32'(want[17]), 32'(got[17]));
                    check_field("missed_steps", want[49:18], got[49:18]);
                end
            end
        end
        pending = status_q.size();
    end

    initial
    begin
        errors = 0;
        pending = 0;
        results_seen = 0;
        passes_seen = 0;
    end

endmodule

>>> tb/tb_multi_axis_step_pulse_generator_core.sv
// Testbench top: drives commands and config writes, paces the output, gives the verdict.
module tb_multi_axis_step_pulse_generator_core;
    import msp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [15:0]           cfg_data;

    int errors, pending, results_seen, passes_seen;
    int items_sent;
    bit burst_mode;

    multi_axis_step_pulse_generator_core uut (.*);

    msp_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .results_seen(results_seen),
        .passes_seen(passes_seen)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("multi_axis_step_pulse_generator_core regression: fail");
        $finish;
    end

    task automatic send_item(logic [1:0] cmd, logic [1:0] motor, logic dir,
                             logic [23:0] steps, logic [23:0] period, logic en);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, en, period, steps, dir, motor};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic tick(int n);
        repeat (n) send_item(CMD_TICK, 2'($urandom), 1'($urandom), 24'($urandom),
                             24'($urandom), 1'($urandom));
    endtask

    // Drain all results, let the block settle, then write both registers.
    task automatic set_regs(logic [15:0] merge, logic [15:0] hold);
        @(posedge clk);
        s_tvalid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        for (int r = 0; r < 2; r++)
        begin
            cfg_valid <= 1;
            cfg_index <= (r == 0) ? REG_MERGE : REG_HOLD;
            cfg_data  <= (r == 0) ? merge : hold;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 0;
    endtask

    task automatic random_item();
        int          sel;
        logic [23:0] steps, period;
        sel = $urandom_range(0, 99);
        steps  = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
        period = ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
        if (sel < 62)
            tick(1);
        else if (sel < 82)
            send_item(CMD_MOVE, 2'($urandom), 1'($urandom), steps, period, 1'($urandom));
        else if (sel < 95)
            send_item(CMD_ENABLE, 2'($urandom), 1'($urandom), steps, period, 1'($urandom));
        else
            send_item(CMD_NONE, 2'($urandom), 1'($urandom), steps, period, 1'($urandom));
    endtask

    // Output side: one long hold-off early on, then random gaps per item.
    initial
    begin
        int gap;
        m_tready = 0;
        @(posedge rst_n);
        repeat (400) @(posedge clk);
        forever
        begin
            gap = burst_mode ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        logic [15:0] merge_set [4];
        logic [15:0] hold_set  [4];
        int drain;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        burst_mode = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: tick while stopped, unused command, short period, zero-step move.
        tick(2);
        send_item(CMD_NONE, 2'd3, 1, 24'hFFFFFF, 24'hFFFFFF, 1);
        send_item(CMD_MOVE, 2'd0, 1, 24'd2, 24'd0, 0);
        tick(6);
        send_item(CMD_MOVE, 2'd1, 0, 24'd0, 24'd1, 0);
        tick(3);
        send_item(CMD_ENABLE, 2'd2, 0, 24'd0, 24'd0, 1);
        send_item(CMD_ENABLE, 2'd2, 0, 24'd0, 24'd0, 0);
        send_item(CMD_MOVE, 2'd3, 1, 24'hFFFFFF, 24'hFFFFFF, 1);
        tick(2);
        send_item(CMD_ENABLE, 2'd3, 1, 24'hFFFFFF, 24'hFFFFFF, 1);
        tick(2);

        // Extreme register values; kill the far-off motor before moving on.
        set_regs(16'hFFFF, 16'hFFFF);
        send_item(CMD_MOVE, 2'd1, 1, 24'd3, 24'd4, 0);
        send_item(CMD_ENABLE, 2'd1, 0, 24'd0, 24'd0, 1);

        merge_set = '{16'd0, 16'hFFFF, 16'd3, 16'($urandom_range(0, 20))};
        hold_set  = '{16'd1, 16'd0, 16'd5, 16'($urandom_range(0, 30))};
        for (int ph = 0; ph < 4; ph++)
        begin
            set_regs(merge_set[ph], hold_set[ph]);
            for (int i = 0; i < 230; i++)
            begin
                if (i % 50 == 0)
                    burst_mode = ($urandom_range(0, 3) == 0);
                random_item();
            end
        end
        burst_mode = 0;

        @(posedge clk);
        s_tvalid <= 0;
        drain = 0;
        while (pending != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (30) @(posedge clk);
        $display("Ran %0d items over 4 register settings plus extremes; %0d results checked,",
                 items_sent, results_seen);
        $display("%0d service passes predicted, %0d mismatches.", passes_seen, errors);
        if (errors == 0 && pending == 0)
            $display("multi_axis_step_pulse_generator_core regression: pass");
        else
            $display("multi_axis_step_pulse_generator_core regression: fail");
        $finish;
    end

endmodule

>>> files.f
sv/msp_pkg.sv
sv/msp_state_ram.sv
sv/msp_toggle_calc.sv
sv/multi_axis_step_pulse_generator_core.sv
sv/msp_checker.sv
tb/msp_checker.sv
tb/tb_multi_axis_step_pulse_generator_core.sv
